/* rtl/scl_pkg.sv */
// Shared types and constants of the size-class LRU cache directory.
// No dependencies; used by every module of the block.
`default_nettype none

package scl_pkg;

  localparam int NUM_CLASSES_DEF = 4;
  localparam int MAX_LINES_DEF   = 16;

  localparam int KEY_W   = 32;
  localparam int LEN_W   = 20;
  localparam int STAMP_W = 48;
  localparam int LINES_W = 5;

  // configuration register map
  localparam int CFG_CLASSES = 4;
  localparam int CFG_SEL_W   = 2;
  localparam int CFG_IDX_W   = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_BASE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END        = 4'd8;

  localparam logic [LEN_W-1:0] LIMIT_RST [CFG_CLASSES] =
    '{20'd1024, 20'd8192, 20'd32768, 20'd102400};
  localparam logic [LINES_W-1:0] LINES_RST = 5'd16;

  typedef enum logic {
    REQ_LOOKUP,
    REQ_INSERT
  } scl_req_e;

  typedef enum logic [1:0] {
    STAT_HIT,
    STAT_MISS,
    STAT_STORED,
    STAT_TOO_BIG
  } scl_status_e;

  // write request to the line store
  typedef struct packed {
    logic en;    // write the stamp
    logic full;  // also write key and length
  } scl_wr_t;

  // result of the shared line compare unit
  typedef struct packed {
    logic empty;  // stamp is zero
    logic match;  // valid line with the requested key
    logic le;     // stamp not above the best stamp so far
  } scl_cmp_t;

endpackage

`default_nettype wire

/* rtl/scl_cfg.sv */
// Class limit and line count registers with the per-class view used by the sequencer.
// Depends on scl_pkg.
`default_nettype none

module scl_cfg import scl_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int MAX_LINES   = MAX_LINES_DEF,
  parameter int CLS_W       = 2,
  parameter int NW          = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LEN_W-1:0]     cfg_data_i,
  input  wire logic [CLS_W-1:0]     cls_i,
  output logic      [LEN_W-1:0]     limit_o,
  output logic      [NW-1:0]        lines_o
);

  logic [LEN_W-1:0]   limit_q [CFG_CLASSES];
  logic [LINES_W-1:0] lines_q [CFG_CLASSES];
  logic [LINES_W-1:0] raw_lines;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CFG_CLASSES; k++) begin
        limit_q[k] <= LIMIT_RST[k];
        lines_q[k] <= LINES_RST;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i < CFG_LINES_BASE) begin
        limit_q[cfg_index_i[CFG_SEL_W-1:0]] <= cfg_data_i;
      end else if (cfg_index_i < CFG_END) begin
        lines_q[cfg_index_i[CFG_SEL_W-1:0]] <= cfg_data_i[LINES_W-1:0];
      end
    end
  end

  // classes without registers: limit 0, one line
  always_comb begin
    limit_o   = '0;
    raw_lines = LINES_W'(1);
    for (int k = 0; k < CFG_CLASSES; k++) begin
      if (32'(cls_i) == k) begin
        limit_o   = limit_q[k];
        raw_lines = lines_q[k];
      end
    end
    if (raw_lines == '0) begin
      lines_o = NW'(1);
    end else if (32'(raw_lines) > MAX_LINES) begin
      lines_o = NW'(MAX_LINES);
    end else begin
      lines_o = NW'(raw_lines);
    end
  end

endmodule

`default_nettype wire

/* rtl/scl_cmp.sv */
// Shared line compare unit: empty test, key match and stamp ordering for one line.
// Depends on scl_pkg.
`default_nettype none

module scl_cmp import scl_pkg::*; (
  input  wire logic [STAMP_W-1:0] stamp_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [KEY_W-1:0]   ref_key_i,
  input  wire logic [STAMP_W-1:0] best_stamp_i,
  output scl_cmp_t                res_o
);

  always_comb begin
    res_o.empty = (stamp_i == '0);
    res_o.match = (stamp_i != '0) && (key_i == ref_key_i);
    res_o.le    = (stamp_i <= best_stamp_i);
  end

endmodule

`default_nettype wire

/* rtl/scl_store.sv */
// Line store: stamp, key and length memories, one read and one write port each,
// plus the stamp clearing pass after reset. Depends on scl_pkg.
`default_nettype none

module scl_store import scl_pkg::*; #(
  parameter int DEPTH = NUM_CLASSES_DEF * MAX_LINES_DEF,
  parameter int EW    = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  output logic                    busy_o,
  input  wire logic               rd_en_i,
  input  wire logic [EW-1:0]      rd_addr_i,
  output logic      [STAMP_W-1:0] rd_stamp_o,
  output logic      [KEY_W-1:0]   rd_key_o,
  output logic      [LEN_W-1:0]   rd_len_o,
  input  wire scl_wr_t            wr_i,
  input  wire logic [EW-1:0]      wr_addr_i,
  input  wire logic [STAMP_W-1:0] wr_stamp_i,
  input  wire logic [KEY_W-1:0]   wr_key_i,
  input  wire logic [LEN_W-1:0]   wr_len_i
);

  logic [STAMP_W-1:0] stamp_mem [DEPTH];
  logic [KEY_W-1:0]   key_mem   [DEPTH];
  logic [LEN_W-1:0]   len_mem   [DEPTH];

  logic          clr_q;
  logic [EW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + EW'(1);
      if (clr_cnt_q == EW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign busy_o = clr_q;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      stamp_mem[clr_cnt_q] <= '0;
    end else if (wr_i.en) begin
      stamp_mem[wr_addr_i] <= wr_stamp_i;
    end
    if (rd_en_i) begin
      rd_stamp_o <= stamp_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.full) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (rd_en_i) begin
      rd_key_o <= key_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.full) begin
      len_mem[wr_addr_i] <= wr_len_i;
    end
    if (rd_en_i) begin
      rd_len_o <= len_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/size_class_lru_cache_directory.sv */
// Size-class LRU cache directory: request sequencer, request clock and result register.
// Top level; depends on scl_pkg, scl_cfg, scl_cmp and scl_store.
//
// Usage: a request beat (req_type_i, key_i, obj_len_i) is taken on in_valid_i & in_ready_o
// and yields exactly one result beat on out_valid_o & out_ready_i. Lookups scan the classes
// and their lines in order for the first valid matching key; inserts pick the first class
// whose limit holds obj_len_i, then take its first empty line or evict the oldest stamp.
// One line is read per cycle from the line store; reads are pipelined one deep.
// An insert first selects its class by limit; lookups and inserts then scan lines. A hit
// restamps its line and a stored insert writes its line before the result moves on; an
// oversize insert tries every class and writes nothing.
// One request is in flight at a time; in_ready_o is low until the result has moved into
// the output register, which may still hold an earlier result while the next request is
// taken. The configuration channel is always ready; the user must write registers only
// while idle, and the block itself has no check that enforces it. After reset the stamp
// memory is cleared and in_ready_o stays low meanwhile. A stalled receiver holds the
// result and blocks the next finish.
`default_nettype none

module size_class_lru_cache_directory import scl_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int MAX_LINES   = MAX_LINES_DEF,
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
  localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LEN_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 req_type_i,
  input  wire logic [KEY_W-1:0]     key_i,
  input  wire logic [LEN_W-1:0]     obj_len_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [1:0]           status_o,
  output logic      [CLS_W-1:0]     class_index_o,
  output logic      [LINE_W-1:0]    line_index_o,
  output logic      [LEN_W-1:0]     stored_len_o,
  output logic                      evicted_o,
  output logic      [KEY_W-1:0]     evicted_key_o
);

  localparam int DEPTH = NUM_CLASSES * MAX_LINES;
  localparam int EW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = LINE_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEL,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_e;

  state_e                 state_q, state_d;
  scl_req_e               req_q, req_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [STAMP_W-1:0]     now_q, now_d;
  logic [STAMP_W-1:0]     rclk_q, rclk_d;
  logic [STAMP_W-1:0]     rclk_inc;

  // scan position
  logic [CLS_W-1:0]       c_q, c_d;
  logic [EW-1:0]          base_q, base_d;
  logic [LINE_W-1:0]      j_q, j_d;
  logic                   iss_q, iss_d;

  // read in flight
  logic                   p_vld_q, p_vld_d;
  logic [LINE_W-1:0]      p_j_q, p_j_d;
  logic [CLS_W-1:0]       p_c_q, p_c_d;
  logic [EW-1:0]          p_addr_q, p_addr_d;
  logic                   p_last_q, p_last_d;

  // insert victim search
  logic                   has_empty_q, has_empty_d;
  logic [LINE_W-1:0]      empty_j_q, empty_j_d;
  logic [STAMP_W-1:0]     best_stamp_q, best_stamp_d;
  logic [LINE_W-1:0]      best_j_q, best_j_d;
  logic [KEY_W-1:0]       best_key_q, best_key_d;

  // pending result and write
  scl_status_e            res_status_q, res_status_d;
  logic [CLS_W-1:0]       res_cls_q, res_cls_d;
  logic [LINE_W-1:0]      res_line_q, res_line_d;
  logic [LEN_W-1:0]       res_len_q, res_len_d;
  logic                   res_ev_q, res_ev_d;
  logic [KEY_W-1:0]       res_evkey_q, res_evkey_d;
  logic [EW-1:0]          wr_addr_q, wr_addr_d;
  logic                   wr_full_q, wr_full_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  scl_status_e            out_status_q, out_status_d;
  logic [CLS_W-1:0]       out_cls_q, out_cls_d;
  logic [LINE_W-1:0]      out_line_q, out_line_d;
  logic [LEN_W-1:0]       out_len_q, out_len_d;
  logic                   out_ev_q, out_ev_d;
  logic [KEY_W-1:0]       out_evkey_q, out_evkey_d;

  logic [LEN_W-1:0]       cls_limit;
  logic [NW-1:0]          cls_lines;
  logic                   last_line;
  logic                   last_class;
  logic                   clr_busy;
  logic                   in_acc;

  logic                   rd_en;
  logic [EW-1:0]          rd_addr;
  logic [STAMP_W-1:0]     rd_stamp;
  logic [KEY_W-1:0]       rd_key;
  logic [LEN_W-1:0]       rd_len;
  scl_wr_t                wr;
  scl_cmp_t               cmp;

  logic                   he;
  logic [LINE_W-1:0]      ej;
  logic                   take_best;
  logic [LINE_W-1:0]      bj;
  logic [KEY_W-1:0]       bk;
  logic [LINE_W-1:0]      pick;

  scl_cfg #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_LINES   (MAX_LINES),
    .CLS_W       (CLS_W),
    .NW          (NW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cls_i       (c_q),
    .limit_o     (cls_limit),
    .lines_o     (cls_lines)
  );

  scl_store #(
    .DEPTH (DEPTH),
    .EW    (EW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_o     (clr_busy),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_stamp_o (rd_stamp),
    .rd_key_o   (rd_key),
    .rd_len_o   (rd_len),
    .wr_i       (wr),
    .wr_addr_i  (wr_addr_q),
    .wr_stamp_i (now_q),
    .wr_key_i   (key_q),
    .wr_len_i   (len_q)
  );

  scl_cmp u_cmp (
    .stamp_i      (rd_stamp),
    .key_i        (rd_key),
    .ref_key_i    (key_q),
    .best_stamp_i (best_stamp_q),
    .res_o        (cmp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !clr_busy;
  assign in_acc      = in_valid_i && in_ready_o;

  assign last_line  = ((NW'(j_q) + NW'(1)) == cls_lines);
  assign last_class = (c_q == CLS_W'(NUM_CLASSES - 1));
  assign rd_addr    = base_q + EW'(j_q);
  assign rclk_inc   = rclk_q + STAMP_W'(1);

  // victim search, folding in the line now returned
  assign he        = has_empty_q || cmp.empty;
  assign ej        = has_empty_q ? empty_j_q : p_j_q;
  assign take_best = (p_j_q == '0) || cmp.le;
  assign bj        = take_best ? p_j_q : best_j_q;
  assign bk        = take_best ? rd_key : best_key_q;
  assign pick      = he ? ej : bj;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    key_d        = key_q;
    len_d        = len_q;
    now_d        = now_q;
    rclk_d       = rclk_q;
    c_d          = c_q;
    base_d       = base_q;
    j_d          = j_q;
    iss_d        = iss_q;
    p_vld_d      = 1'b0;
    p_j_d        = p_j_q;
    p_c_d        = p_c_q;
    p_addr_d     = p_addr_q;
    p_last_d     = p_last_q;
    has_empty_d  = has_empty_q;
    empty_j_d    = empty_j_q;
    best_stamp_d = best_stamp_q;
    best_j_d     = best_j_q;
    best_key_d   = best_key_q;
    res_status_d = res_status_q;
    res_cls_d    = res_cls_q;
    res_line_d   = res_line_q;
    res_len_d    = res_len_q;
    res_ev_d     = res_ev_q;
    res_evkey_d  = res_evkey_q;
    wr_addr_d    = wr_addr_q;
    wr_full_d    = wr_full_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_cls_d    = out_cls_q;
    out_line_d   = out_line_q;
    out_len_d    = out_len_q;
    out_ev_d     = out_ev_q;
    out_evkey_d  = out_evkey_q;
    rd_en        = 1'b0;
    wr           = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d        = scl_req_e'(req_type_i);
          key_d        = key_i;
          len_d        = obj_len_i;
          now_d        = rclk_q;
          rclk_d       = (rclk_inc == '0) ? STAMP_W'(1) : rclk_inc;
          c_d          = '0;
          base_d       = '0;
          j_d          = '0;
          iss_d        = 1'b1;
          has_empty_d  = 1'b0;
          res_status_d = STAT_MISS;
          res_cls_d    = '0;
          res_line_d   = '0;
          res_len_d    = '0;
          res_ev_d     = 1'b0;
          res_evkey_d  = '0;
          state_d      = (scl_req_e'(req_type_i) == REQ_INSERT) ? S_SEL : S_SCAN;
        end
      end

      // one class limit compared per cycle
      S_SEL: begin
        if (cls_limit >= len_q) begin
          state_d = S_SCAN;
        end else if (last_class) begin
          res_status_d = STAT_TOO_BIG;
          state_d      = S_RESP;
        end else begin
          c_d    = c_q + CLS_W'(1);
          base_d = base_q + EW'(MAX_LINES);
        end
      end

      S_SCAN: begin
        if (iss_q) begin
          rd_en    = 1'b1;
          p_vld_d  = 1'b1;
          p_j_d    = j_q;
          p_c_d    = c_q;
          p_addr_d = rd_addr;
          p_last_d = last_line && (req_q == REQ_INSERT || last_class);
          if (!last_line) begin
            j_d = j_q + LINE_W'(1);
          end else if (req_q == REQ_LOOKUP && !last_class) begin
            j_d    = '0;
            c_d    = c_q + CLS_W'(1);
            base_d = base_q + EW'(MAX_LINES);
          end else begin
            iss_d = 1'b0;
          end
        end
        if (p_vld_q) begin
          if (req_q == REQ_LOOKUP) begin
            if (cmp.match) begin
              res_status_d = STAT_HIT;
              res_cls_d    = p_c_q;
              res_line_d   = p_j_q;
              res_len_d    = rd_len;
              wr_addr_d    = p_addr_q;
              wr_full_d    = 1'b0;
              iss_d        = 1'b0;
              p_vld_d      = 1'b0;
              state_d      = S_WRITE;
            end else if (p_last_q) begin
              state_d = S_RESP;
            end
          end else begin
            has_empty_d = he;
            empty_j_d   = ej;
            best_j_d    = bj;
            best_key_d  = bk;
            if (take_best) begin
              best_stamp_d = rd_stamp;
            end
            if (p_last_q) begin
              res_status_d = STAT_STORED;
              res_cls_d    = p_c_q;
              res_line_d   = pick;
              res_ev_d     = !he;
              res_evkey_d  = he ? '0 : bk;
              wr_addr_d    = base_q + EW'(pick);
              wr_full_d    = 1'b1;
              state_d      = S_WRITE;
            end
          end
        end
      end

      S_WRITE: begin
        wr.en   = 1'b1;
        wr.full = wr_full_q;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_cls_d    = res_cls_q;
          out_line_d   = res_line_q;
          out_len_d    = res_len_q;
          out_ev_d     = res_ev_q;
          out_evkey_d  = res_evkey_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rclk_q      <= STAMP_W'(1);
      iss_q       <= 1'b0;
      p_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rclk_q      <= rclk_d;
      iss_q       <= iss_d;
      p_vld_q     <= p_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    len_q        <= len_d;
    now_q        <= now_d;
    c_q          <= c_d;
    base_q       <= base_d;
    j_q          <= j_d;
    p_j_q        <= p_j_d;
    p_c_q        <= p_c_d;
    p_addr_q     <= p_addr_d;
    p_last_q     <= p_last_d;
    has_empty_q  <= has_empty_d;
    empty_j_q    <= empty_j_d;
    best_stamp_q <= best_stamp_d;
    best_j_q     <= best_j_d;
    best_key_q   <= best_key_d;
    res_status_q <= res_status_d;
    res_cls_q    <= res_cls_d;
    res_line_q   <= res_line_d;
    res_len_q    <= res_len_d;
    res_ev_q     <= res_ev_d;
    res_evkey_q  <= res_evkey_d;
    wr_addr_q    <= wr_addr_d;
    wr_full_q    <= wr_full_d;
    out_status_q <= out_status_d;
    out_cls_q    <= out_cls_d;
    out_line_q   <= out_line_d;
    out_len_q    <= out_len_d;
    out_ev_q     <= out_ev_d;
    out_evkey_q  <= out_evkey_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign class_index_o = out_cls_q;
  assign line_index_o  = out_line_q;
  assign stored_len_o  = out_len_q;
  assign evicted_o     = out_ev_q;
  assign evicted_key_o = out_evkey_q;

endmodule

`default_nettype wire

/* tb/size_class_lru_cache_directory_test.sv */
// Self-checking testbench for the size-class LRU cache directory.
// Predicts every lookup and insert result and checks it; needs scl_pkg and the block's RTL.
`timescale 1ns / 1ps

module size_class_lru_cache_directory_test;
  import scl_pkg::*;

  localparam int NCLS   = NUM_CLASSES_DEF;
  localparam int NLINES = MAX_LINES_DEF;
  localparam int NPHASE = 8;
  localparam int PHASE_ITEMS = 135;

  typedef struct packed {
    scl_status_e        status;
    logic [1:0]         cls;
    logic [3:0]         line;
    logic [LEN_W-1:0]   slen;
    logic               ev;
    logic [KEY_W-1:0]   evkey;
  } dir_result_t;

  // Directory model plus the queue of results still owed by the block.
  class dir_scoreboard;
    logic [LEN_W-1:0]   limit [NCLS];
    logic [LINES_W-1:0] lines [NCLS];
    logic [STAMP_W-1:0] line_stamp [NCLS*NLINES];
    logic [KEY_W-1:0]   line_key [NCLS*NLINES];
    logic [LEN_W-1:0]   line_len [NCLS*NLINES];
    logic [STAMP_W-1:0] req_clock;
    dir_result_t        expected_results [$];
    int                 mismatches;

    function new();
      foreach (limit[i]) begin
        limit[i] = LIMIT_RST[i];
        lines[i] = LINES_RST;
      end
      foreach (line_stamp[i]) begin
        line_stamp[i] = '0;
        line_key[i]   = '0;
        line_len[i]   = '0;
      end
      req_clock  = 48'd1;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
      if (idx < CFG_LINES_BASE) begin
        limit[idx - CFG_LIMIT_BASE] = data;
      end else if (idx < CFG_END) begin
        lines[idx - CFG_LINES_BASE] = data[LINES_W-1:0];
      end
    endfunction

    // 0 acts as one line, anything above the array size as the full array
    function int line_count(int c);
      int n;
      n = lines[c];
      if (n == 0) n = 1;
      if (n > NLINES) n = NLINES;
      return n;
    endfunction

    function dir_result_t predict_outcome(scl_req_e req, logic [KEY_W-1:0] key,
                                          logic [LEN_W-1:0] len);
      dir_result_t        r;
      logic [STAMP_W-1:0] now;
      logic [STAMP_W-1:0] best;
      int                 c, j, n, base, pick;
      bit                 found;
      r = '0;
      r.status = STAT_MISS;
      now = req_clock;
      req_clock = req_clock + 48'd1;
      if (req_clock == '0) req_clock = 48'd1;
      if (req == REQ_LOOKUP) begin
        found = 0;
        for (c = 0; c < NCLS && !found; c++) begin
          n = line_count(c);
          for (j = 0; j < n && !found; j++) begin
            base = c * NLINES + j;
            if (line_stamp[base] != '0 && line_key[base] == key) begin
              line_stamp[base] = now;
              r.status = STAT_HIT;
              r.cls    = 2'(c);
              r.line   = 4'(j);
              r.slen   = line_len[base];
              found    = 1;
            end
          end
        end
      end else begin
        c = 0;
        while (c < NCLS && limit[c] < len) c++;
        if (c == NCLS) begin
          r.status = STAT_TOO_BIG;
        end else begin
          n = line_count(c);
          base = c * NLINES;
          pick = n;
          for (j = 0; j < n; j++) begin
            if (pick == n && line_stamp[base + j] == '0) pick = j;
          end
          if (pick == n) begin
            // oldest stamp loses; on equal stamps the later line wins the eviction
            best = line_stamp[base];
            pick = 0;
            for (j = 0; j < n; j++) begin
              if (line_stamp[base + j] <= best) begin
                best = line_stamp[base + j];
                pick = j;
              end
            end
            r.ev    = 1'b1;
            r.evkey = line_key[base + pick];
          end
          line_stamp[base + pick] = now;
          line_key[base + pick]   = key;
          line_len[base + pick]   = len;
          r.status = STAT_STORED;
          r.cls    = 2'(c);
          r.line   = 4'(pick);
        end
      end
      return r;
    endfunction

    function void note_request(scl_req_e req, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
      expected_results.push_back(predict_outcome(req, key, len));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string what, logic [KEY_W-1:0] got_v, logic [KEY_W-1:0] want_v);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got_v, want_v);
      mismatches++;
    endtask

    task check_result(dir_result_t got);
      dir_result_t want;
      if (expected_results.size() == 0) begin
        report("unexpected result beat, status", got.status, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.cls != want.cls)        report("class_index", got.cls, want.cls);
        if (got.line != want.line)      report("line_index", got.line, want.line);
        if (got.slen != want.slen)      report("stored_len", got.slen, want.slen);
        if (got.ev != want.ev)          report("evicted", got.ev, want.ev);
        if (got.evkey != want.evkey)    report("evicted_key", got.evkey, want.evkey);
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [LEN_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 req_type_i;
  logic [KEY_W-1:0]     key_i;
  logic [LEN_W-1:0]     obj_len_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [1:0]           status_o;
  logic [1:0]           class_index_o;
  logic [3:0]           line_index_o;
  logic [LEN_W-1:0]     stored_len_o;
  logic                 evicted_o;
  logic [KEY_W-1:0]     evicted_key_o;

  dir_scoreboard    sb;
  bit               no_idle;
  logic [LEN_W-1:0] cur_limit [NCLS];
  logic [KEY_W-1:0] key_pool [16];

  size_class_lru_cache_directory u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .obj_len_i     (obj_len_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .class_index_o (class_index_o),
    .line_index_o  (line_index_o),
    .stored_len_o  (stored_len_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_800_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Called right after a posedge; returns at the posedge that accepts the beat.
  task automatic send_request(scl_req_e req, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = req;
    key_i      = key;
    obj_len_i  = len;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(req, key, len);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_register(idx, data);
  endtask

  // Every result has to be back before the registers move.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_phase(int p);
    logic [LEN_W-1:0]   lim [NCLS];
    logic [LINES_W-1:0] cnt [NCLS];
    case (p)
      1: begin
        lim = '{20'd0, 20'd100, 20'd5000, 20'hFFFFF};
        cnt = '{5'd1, 5'd2, 5'd3, 5'd4};
      end
      2: begin
        lim = '{20'hFFFFF, 20'hFFFFF, 20'd0, 20'd0};
        cnt = '{5'd16, 5'd0, 5'd31, 5'd17};
      end
      4: begin
        lim = '{20'd0, 20'd0, 20'd0, 20'd0};
        cnt = '{5'd0, 5'd0, 5'd0, 5'd0};
      end
      NPHASE - 1: begin
        lim = LIMIT_RST;
        cnt = '{LINES_RST, LINES_RST, LINES_RST, LINES_RST};
      end
      default: begin
        for (int i = 0; i < NCLS; i++) begin
          case (p)
            3:       lim[i] = 20'(i * 2000 + $urandom_range(0, 1999));
            5:       lim[i] = 20'($urandom_range(0, 20'hFFFFF));
            default: lim[i] = 20'($urandom_range(0, 3000));
          endcase
          case (p)
            3:       cnt[i] = 5'($urandom_range(0, 31));
            5:       cnt[i] = 5'($urandom_range(1, 6));
            default: cnt[i] = 5'($urandom_range(0, 4));
          endcase
        end
      end
    endcase
    for (int i = 0; i < NCLS; i++) begin
      write_register(CFG_LIMIT_BASE + 4'(i), lim[i]);
      write_register(CFG_LINES_BASE + 4'(i), {15'($urandom), cnt[i]});
      cur_limit[i] = lim[i];
    end
    // unmapped index, must be ignored
    write_register(CFG_END + 4'($urandom_range(0, 7)), 20'($urandom));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // lengths cluster on the class limits so every class and the oversize path get hit
  function automatic logic [LEN_W-1:0] pick_length();
    logic [LEN_W-1:0] lim;
    int               sel;
    lim = cur_limit[$urandom_range(0, NCLS - 1)];
    sel = $urandom_range(0, 9);
    if (sel < 3) return lim;
    if (sel < 5) return lim + 20'd1;
    if (sel < 8) return 20'($urandom_range(0, lim));
    if (sel == 8) return '0;
    return 20'($urandom);
  endfunction

  task automatic run_directed();
    send_request(REQ_LOOKUP, 32'h0000_0000, 20'h00000);   // empty directory
    send_request(REQ_INSERT, 32'h0000_0000, 20'd0);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 20'd1024);     // exactly at class 0 limit
    send_request(REQ_INSERT, 32'h1234_5678, 20'd1025);
    send_request(REQ_INSERT, 32'h8765_4321, 20'd8192);
    send_request(REQ_INSERT, 32'hA5A5_5A5A, 20'd32769);
    send_request(REQ_INSERT, 32'hDEAD_BEEF, 20'd102400);
    send_request(REQ_INSERT, 32'hC0FF_EE00, 20'd102401);   // too large everywhere
    send_request(REQ_INSERT, 32'h0BAD_F00D, 20'hFFFFF);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF);
    send_request(REQ_LOOKUP, 32'h0000_0000, 20'h00000);
    send_request(REQ_INSERT, 32'h1234_5678, 20'd5);        // second copy, lower class
    send_request(REQ_LOOKUP, 32'h1234_5678, 20'd0);
    send_request(REQ_LOOKUP, 32'hC0FF_EE00, 20'd0);
    send_request(REQ_LOOKUP, 32'hDEAD_BEEF, 20'd77);
    send_request(REQ_INSERT, 32'h5555_AAAA, 20'd32768);
    send_request(REQ_LOOKUP, 32'h5555_AAAA, 20'd0);
    send_request(REQ_LOOKUP, 32'h7777_7777, 20'd0);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    req_type_i  = 1'b0;
    key_i       = '0;
    obj_len_i   = '0;
    no_idle     = 1'b0;
    cur_limit   = LIMIT_RST;
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NPHASE; p++) begin
      if (p == 0) begin
        run_directed();
      end else begin
        wait_idle();
        program_phase(p);
      end
      foreach (key_pool[i]) key_pool[i] = $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 45) begin
          send_request(REQ_LOOKUP, pick_key(), 20'($urandom));
        end else begin
          send_request(REQ_INSERT, pick_key(), pick_length());
        end
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: random back-pressure, sometimes held until a beat is waiting
  initial begin
    int          stall;
    dir_result_t got;
    out_ready_i = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 18);
      @(negedge clk_i);
      if (stall == 0) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk_i); while (out_valid_o !== 1'b1);
          @(negedge clk_i);
        end
        repeat (stall - 1) @(negedge clk_i);
        out_ready_i = 1'b1;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.status = scl_status_e'(status_o);
      got.cls    = class_index_o;
      got.line   = line_index_o;
      got.slen   = stored_len_o;
      got.ev     = evicted_o;
      got.evkey  = evicted_key_o;
      sb.check_result(got);
    end
  end

endmodule

/* files.f */
rtl/scl_pkg.sv
rtl/scl_cfg.sv
rtl/scl_cmp.sv
rtl/scl_store.sv
rtl/size_class_lru_cache_directory.sv
tb/size_class_lru_cache_directory_test.sv
